// ===== sv/skl_pkg.sv =====
package skl_pkg;

  localparam int FRAC_BITS = 11;
  localparam int HOLD_W    = 16;

  localparam int SAMPLE_W  = 16;
  localparam int THR_W     = 15;
  localparam int GAIN_W    = 7;
  localparam int HLEN_W    = 16;
  localparam int OUT_W     = 19;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 2'd2;

  localparam logic [THR_W-1:0]  THR_RESET  = 15'd20480;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 7'd10;
  localparam logic [HLEN_W-1:0] HOLD_RESET = 16'd10000;

  localparam int ONE_CODE = 1 << FRAC_BITS;
  localparam int EXC_W    = SAMPLE_W;
  localparam int DIV_W    = $clog2(ONE_CODE + (1 << (SAMPLE_W - 1)) + 1);
  localparam int MAG_W    = $clog2((1 << THR_W) - 1 + ONE_CODE);
  localparam int PROD_W   = MAG_W + GAIN_W;
  localparam int DIV10_STEPS = (PROD_W + 1) / 2;
  localparam int DIV10_W  = 2 * DIV10_STEPS;

  localparam int OUT_POS_MAX = (1 << (OUT_W - 1)) - 1;
  localparam int OUT_NEG_MAG = 1 << (OUT_W - 1);
  localparam int OVER_LIM    = 10 * ONE_CODE;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       connected;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] sample_out;
    logic                    threshold_light;
    logic                    clip_light;
  } out_t;

  function automatic logic [HOLD_W-1:0] hold_sat(input logic [HLEN_W-1:0] h);
    logic [HOLD_W-1:0] r;
    if ((32'(h) >> HOLD_W) != 32'd0) begin
      r = '1;
    end else begin
      r = HOLD_W'(h);
    end
    return r;
  endfunction

endpackage

// ===== sv/soft_knee_limiter.sv =====
// Soft knee limiter with threshold and over hold lights.
// Input channel: in_valid_i / in_ready_o, one beat carries a sample and the
// jack-connected flag. Output channel: out_valid_o / out_ready_i, one beat
// per input beat carrying the limited, scaled sample and both lights.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (threshold, gain in tenths, hold length); write only while idle.
// One item is in work at a time. A sample at or below the threshold, or a
// disconnected input, goes from accept through the bit-serial gain
// multiply and the two-bit-a-cycle divide by ten to the output register.
// A limited sample first passes the bit-serial restoring divider that
// forms the knee. A new sample is accepted only after the result has
// entered the output register.
// A stalled receiver holds one finished beat while the next sample is
// worked; the engine then waits for the output register to drain.
// Reset loads the default threshold (10 V), gain (1.0) and hold length
// (10000), clears both hold counters and empties the output register.
module soft_knee_limiter
  import skl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FOLD,
    ST_SCALE,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [THR_W-1:0]  thr_q;
  logic [GAIN_W-1:0] gain_q;
  logic [HLEN_W-1:0] hlen_q;
  logic              neg_q;
  logic              lim_q;
  logic              conn_q;
  out_t              out_q;
  logic              out_valid_q;

  logic                 accept;
  logic [SAMPLE_W-1:0]  abs_in;
  logic                 lim_in;
  logic                 div_start;
  logic                 div_done;
  logic [FRAC_BITS-1:0] div_quo;
  logic                 scl_start;
  logic [MAG_W-1:0]     scl_mag;
  logic                 scl_done;
  logic [DIV10_W-1:0]   scl_quo;
  logic                 commit;
  logic                 over_hit;
  logic [OUT_W-1:0]     y;
  logic [OUT_W-1:0]     pos_sat;
  logic [OUT_W-1:0]     neg_sat;
  logic                 thr_light;
  logic                 clip_lit;

  assign in_ready_o = state_q == ST_IDLE;
  assign accept     = in_valid_i && in_ready_o;

  assign abs_in = in_data_i.sample_in[SAMPLE_W-1] ? SAMPLE_W'(-in_data_i.sample_in)
                                                  : SAMPLE_W'(in_data_i.sample_in);
  assign lim_in = in_data_i.connected && (abs_in > SAMPLE_W'(thr_q));

  assign div_start = accept && lim_in;
  assign scl_start = (accept && !lim_in) || (state_q == ST_FOLD && div_done);

  always_comb begin
    if (state_q == ST_FOLD) begin
      scl_mag = MAG_W'(thr_q) + MAG_W'(div_quo);
    end else if (!in_data_i.connected) begin
      scl_mag = MAG_W'(ONE_CODE);
    end else begin
      scl_mag = MAG_W'(abs_in);
    end
  end

  skl_fold_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .exc_i   (EXC_W'(abs_in - SAMPLE_W'(thr_q))),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  skl_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scl_start),
    .gain_i  (gain_q),
    .mag_i   (scl_mag),
    .done_o  (scl_done),
    .quo_o   (scl_quo)
  );

  assign pos_sat = (scl_quo > DIV10_W'(OUT_POS_MAX)) ? OUT_W'(OUT_POS_MAX) : OUT_W'(scl_quo);
  assign neg_sat = (scl_quo > DIV10_W'(OUT_NEG_MAG)) ? OUT_W'(OUT_NEG_MAG) : OUT_W'(scl_quo);
  assign y       = neg_q ? OUT_W'(-neg_sat) : pos_sat;
  assign over_hit = conn_q && !neg_q && (32'(pos_sat) > 32'(OVER_LIM));

  assign commit = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  skl_hold u_thr_hold (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .commit_i   (commit),
    .load_i     (lim_q),
    .hold_len_i (hlen_q),
    .light_o    (thr_light)
  );

  skl_hold u_over_hold (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .commit_i   (commit),
    .load_i     (over_hit),
    .hold_len_i (hlen_q),
    .light_o    (clip_lit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_RESET;
      gain_q <= GAIN_RESET;
      hlen_q <= HOLD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_THRESHOLD: thr_q  <= THR_W'(cfg_data_i);
        REG_GAIN:      gain_q <= GAIN_W'(cfg_data_i);
        REG_HOLD:      hlen_q <= HLEN_W'(cfg_data_i);
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      neg_q       <= 1'b0;
      lim_q       <= 1'b0;
      conn_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            neg_q   <= in_data_i.connected && in_data_i.sample_in[SAMPLE_W-1];
            lim_q   <= lim_in;
            conn_q  <= in_data_i.connected;
            state_q <= lim_in ? ST_FOLD : ST_SCALE;
          end
        end
        ST_FOLD: begin
          if (div_done) begin
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (scl_done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (commit) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q.sample_out      <= y;
      out_q.threshold_light <= thr_light;
      out_q.clip_light      <= clip_lit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/skl_fold_div.sv =====
module skl_fold_div
  import skl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [EXC_W-1:0]     exc_i,
  output logic                 done_o,
  output logic [FRAC_BITS-1:0] quo_o
);

  localparam int CNT_W = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(FRAC_BITS - 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [DIV_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     dvs_q, dvs_d;
  logic [FRAC_BITS-1:0] quo_q, quo_d;
  logic [DIV_W:0]       rem2;
  logic                 fits;

  assign rem2 = {rem_q, 1'b0};
  assign fits = rem2 >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        cnt_d  = '0;
        rem_d  = DIV_W'(exc_i);
        dvs_d  = DIV_W'(ONE_CODE) + DIV_W'(exc_i);
      end
    end else begin
      rem_d = fits ? DIV_W'(rem2 - {1'b0, dvs_q}) : DIV_W'(rem2);
      quo_d = {quo_q[FRAC_BITS-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== sv/skl_scale.sv =====
module skl_scale
  import skl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [GAIN_W-1:0]  gain_i,
  input  logic [MAG_W-1:0]   mag_i,
  output logic               done_o,
  output logic [DIV10_W-1:0] quo_o
);

  localparam int STEPS_MAX = (DIV10_STEPS > GAIN_W) ? DIV10_STEPS : GAIN_W;
  localparam int CNT_W     = $clog2(STEPS_MAX);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(GAIN_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV10_STEPS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV
  } state_e;

  state_e             state_q;
  logic               done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [DIV10_W-1:0] work_q;
  logic [PROD_W-1:0]  mcand_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [3:0]         rem_q;

  logic [5:0]         trial;
  logic [1:0]         digit;
  logic [5:0]         sub;

  assign trial = {rem_q, work_q[DIV10_W-1 -: 2]};

  always_comb begin
    if (trial >= 6'd30) begin
      digit = 2'd3;
      sub   = 6'd30;
    end else if (trial >= 6'd20) begin
      digit = 2'd2;
      sub   = 6'd20;
    end else if (trial >= 6'd10) begin
      digit = 2'd1;
      sub   = 6'd10;
    end else begin
      digit = 2'd0;
      sub   = 6'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      work_q  <= '0;
      mcand_q <= '0;
      gain_q  <= '0;
      rem_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          done_q <= 1'b0;
          if (start_i) begin
            state_q <= S_MUL;
            cnt_q   <= '0;
            work_q  <= '0;
            rem_q   <= '0;
            mcand_q <= PROD_W'(mag_i);
            gain_q  <= gain_i;
          end
        end
        S_MUL: begin
          done_q <= 1'b0;
          if (gain_q[0]) begin
            work_q <= work_q + DIV10_W'(mcand_q);
          end
          mcand_q <= {mcand_q[PROD_W-2:0], 1'b0};
          gain_q  <= gain_q >> 1;
          if (cnt_q == MUL_LAST) begin
            state_q <= S_DIV;
            cnt_q   <= '0;
          end else begin
            cnt_q   <= cnt_q + 1'b1;
          end
        end
        S_DIV: begin
          work_q <= {work_q[DIV10_W-3:0], digit};
          rem_q  <= 4'(trial - sub);
          cnt_q  <= cnt_q + 1'b1;
          done_q <= cnt_q == DIV_LAST;
          if (cnt_q == DIV_LAST) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign quo_o  = work_q;

endmodule

// ===== sv/skl_hold.sv =====
module skl_hold
  import skl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              commit_i,
  input  logic              load_i,
  input  logic [HLEN_W-1:0] hold_len_i,
  output logic              light_o
);

  logic [HOLD_W-1:0] cnt_q, cnt_d;
  logic [HOLD_W-1:0] cur;

  assign cur     = load_i ? hold_sat(hold_len_i) : cnt_q;
  assign light_o = cur != '0;

  always_comb begin
    cnt_d = cnt_q;
    if (commit_i && light_o) begin
      cnt_d = cur - 1'b1;
    end else if (commit_i) begin
      cnt_d = cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule
